// ----- hw/rtl/blkcd_pkg.sv -----
// Package for the buffer cache directory.
// Holds transfer payload types, slot row type, action and status codes.
// No dependencies.
`default_nettype none

package blkcd_pkg;

    localparam logic [2:0] ACT_GET     = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_RELEASE = 3'd2;
    localparam logic [2:0] ACT_PIN     = 3'd3;
    localparam logic [2:0] ACT_UNPIN   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_UNREF   = 2'd3;

    localparam logic [7:0]  COUNT_MAX       = 8'd255;
    localparam logic [31:0] DISK_BLOCKS_RST = 32'd4096;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] device_id;
        logic [31:0] block_number;
        logic [4:0]  slot_index;
    } t_in;

    typedef struct packed {
        logic [4:0]  result_slot;
        logic        hit;
        logic        fill_needed;
        logic        write_back;
        logic [31:0] old_block_number;
        logic        forced_eviction;
        logic        write_through;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic        in_use;
        logic        data_valid;
        logic        dirty;
        logic [7:0]  ref_count;
        logic [15:0] tag_device;
        logic [31:0] tag_block;
    } t_row;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/block_cache_directory.sv -----
// Top level of the buffer cache directory: disk size register, result register,
// sequencer and slot store. Depends on blkcd_pkg, blkcd_ctrl, blkcd_slot_store.
// The directory serves one request at a time and holds o_in_stall high while it works.
// A get scans every slot through the store's single read port before its result is
// valid. Write, pin, unpin, unknown actions and a release that leaves references skip
// the scan and fetch only their own slot. A release that drops the count to zero adds
// a rank sweep over every slot after its result is posted, before the next request is
// taken. The result sits in an output register, so the next request is taken while a
// result waits; a finished request holds until that register is free. The user must
// write the disk block count by i_cfg_we only while no request is in flight; the block
// itself does not enforce this.
`default_nettype none

module block_cache_directory
    import blkcd_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  t_in          i_in_data,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output t_out         o_out_data,
    input  wire          i_cfg_we,
    input  wire  [31:0]  i_cfg_wdata
);

    localparam int SW = $clog2(SLOT_COUNT);

    logic [31:0]   r_disk_blocks;
    logic          r_out_valid;
    t_out          r_out;

    logic          busy;
    logic          start;
    logic          out_free;
    logic          done;
    t_out          result;
    t_mem_ctl      mem_ctl;
    logic [SW-1:0] rd_addr;
    logic [SW-1:0] wr_addr;
    t_row          wr_row;
    logic [SW-1:0] wr_rank;
    t_row          rd_row;
    logic [SW-1:0] rd_rank;

    assign o_in_stall  = busy;
    assign start       = i_in_valid && !busy;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_blocks <= DISK_BLOCKS_RST;
        end else if (i_cfg_we) begin
            r_disk_blocks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    blkcd_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_item             (i_in_data),
        .i_disk_block_count (r_disk_blocks),
        .i_out_free         (out_free),
        .i_rd_row           (rd_row),
        .i_rd_rank          (rd_rank),
        .o_busy             (busy),
        .o_mem_ctl          (mem_ctl),
        .o_rd_addr          (rd_addr),
        .o_wr_addr          (wr_addr),
        .o_wr_row           (wr_row),
        .o_wr_rank          (wr_rank),
        .o_done             (done),
        .o_result           (result)
    );

    blkcd_slot_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_row  (wr_row),
        .i_wr_rank (wr_rank),
        .o_rd_row  (rd_row),
        .o_rd_rank (rd_rank)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/blkcd_slot_store.sv -----
// Slot store: one row per slot with tag, marks, reference count and rank.
// One read and one write port, registered read; per-row init bits give reset values.
// Depends on blkcd_pkg.
`default_nettype none

module blkcd_slot_store
    import blkcd_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  t_mem_ctl                       i_ctl,
    input  wire  [$clog2(SLOT_COUNT)-1:0]  i_rd_addr,
    input  wire  [$clog2(SLOT_COUNT)-1:0]  i_wr_addr,
    input  t_row                           i_wr_row,
    input  wire  [$clog2(SLOT_COUNT)-1:0]  i_wr_rank,
    output t_row                           o_rd_row,
    output logic [$clog2(SLOT_COUNT)-1:0]  o_rd_rank
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam logic [SW-1:0] RANK_TOP = SW'(SLOT_COUNT - 1);

    t_row            r_mem      [SLOT_COUNT];
    logic [SW-1:0]   r_rank_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_init;

    t_row            r_rd_row;
    logic [SW-1:0]   r_rd_rank;
    logic [SW-1:0]   r_rd_addr;
    logic            r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr]      <= i_wr_row;
            r_rank_mem[i_wr_addr] <= i_wr_rank;
        end
        if (i_ctl.rd_en) begin
            r_rd_row  <= r_mem[i_rd_addr];
            r_rd_rank <= r_rank_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
            r_rd_init <= r_init[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_ctl.wr_en) begin
            r_init[i_wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        if (r_rd_init) begin
            o_rd_row  = r_rd_row;
            o_rd_rank = r_rd_rank;
        end else begin
            o_rd_row  = '0;
            o_rd_rank = RANK_TOP - r_rd_addr;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/blkcd_ctrl.sv -----
// Sequencer of the directory: slot scan, row fetch, row update, rank sweep.
// One tag compare and one shared count adder; scan and sweep step one slot per cycle.
// Depends on blkcd_pkg; drives blkcd_slot_store.
`default_nettype none

module blkcd_ctrl
    import blkcd_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  t_in                            i_item,
    input  wire  [31:0]                    i_disk_block_count,
    input  wire                            i_out_free,
    input  t_row                           i_rd_row,
    input  wire  [$clog2(SLOT_COUNT)-1:0]  i_rd_rank,
    output logic                           o_busy,
    output t_mem_ctl                       o_mem_ctl,
    output logic [$clog2(SLOT_COUNT)-1:0]  o_rd_addr,
    output logic [$clog2(SLOT_COUNT)-1:0]  o_wr_addr,
    output t_row                           o_wr_row,
    output logic [$clog2(SLOT_COUNT)-1:0]  o_wr_rank,
    output logic                           o_done,
    output t_out                           o_result
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int XW = (SW > 5) ? SW : 5;
    localparam logic [SW:0]   CNT_END  = (SW+1)'(SLOT_COUNT);
    localparam logic [SW-1:0] RANK_TOP = SW'(SLOT_COUNT - 1);
    localparam logic [XW:0]   SLOT_LIM = (XW+1)'(SLOT_COUNT);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_FETCH  = 5'b00100,
        S_UPDATE = 5'b01000,
        S_SWEEP  = 5'b10000
    } t_state;

    t_state        r_state,     n_state;
    t_in           r_item,      n_item;
    logic [SW:0]   r_cnt,       n_cnt;
    logic [SW-1:0] r_pidx,      n_pidx;
    logic          r_hit_found, n_hit_found;
    logic [SW-1:0] r_hit_idx,   n_hit_idx;
    logic          r_vic_found, n_vic_found;
    logic [SW-1:0] r_vic_idx,   n_vic_idx;
    logic [SW-1:0] r_vic_rank,  n_vic_rank;
    logic [SW-1:0] r_zero_idx,  n_zero_idx;
    logic [SW-1:0] r_slot,      n_slot;
    logic [SW-1:0] r_old_rank,  n_old_rank;

    logic [XW-1:0] item_slot_x;
    logic [XW-1:0] res_slot_x;
    logic [SW-1:0] item_addr;
    logic          ok_slot;
    logic          tag_match;
    logic [31:0]   cmp_block;
    logic          out_of_range;
    logic          cnt_up;
    logic [7:0]    cnt_sum;
    t_row          row_n;

    assign item_slot_x = XW'(r_item.slot_index);
    assign item_addr   = item_slot_x[SW-1:0];
    assign ok_slot     = ({1'b0, item_slot_x} < SLOT_LIM);
    assign res_slot_x  = XW'(r_slot);

    assign tag_match = i_rd_row.in_use
                    && (i_rd_row.tag_device == r_item.device_id)
                    && (i_rd_row.tag_block == r_item.block_number);

    assign cmp_block    = (r_item.action == ACT_GET) ? r_item.block_number
                                                     : i_rd_row.tag_block;
    assign out_of_range = (cmp_block >= i_disk_block_count);

    assign cnt_up  = (r_item.action == ACT_GET) || (r_item.action == ACT_PIN);
    assign cnt_sum = cnt_up ? (i_rd_row.ref_count + 8'd1) : (i_rd_row.ref_count - 8'd1);

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cnt       = r_cnt;
        n_pidx      = r_pidx;
        n_hit_found = r_hit_found;
        n_hit_idx   = r_hit_idx;
        n_vic_found = r_vic_found;
        n_vic_idx   = r_vic_idx;
        n_vic_rank  = r_vic_rank;
        n_zero_idx  = r_zero_idx;
        n_slot      = r_slot;
        n_old_rank  = r_old_rank;
        o_mem_ctl   = '0;
        o_rd_addr   = r_cnt[SW-1:0];
        o_wr_addr   = r_slot;
        o_wr_row    = i_rd_row;
        o_wr_rank   = i_rd_rank;
        o_done      = 1'b0;
        o_result    = '0;
        row_n       = i_rd_row;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item      = i_item;
                    n_cnt       = '0;
                    n_hit_found = 1'b0;
                    n_vic_found = 1'b0;
                    n_zero_idx  = '0;
                    n_state     = (i_item.action == ACT_GET) ? S_SCAN : S_FETCH;
                end
            end

            S_SCAN: begin
                if (r_cnt != CNT_END) begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_pidx          = r_cnt[SW-1:0];
                    n_cnt           = r_cnt + 1'b1;
                end
                if (r_cnt != '0) begin
                    if (tag_match && !r_hit_found) begin
                        n_hit_found = 1'b1;
                        n_hit_idx   = r_pidx;
                    end
                    if ((i_rd_row.ref_count == 8'd0)
                        && (!r_vic_found || (i_rd_rank < r_vic_rank))) begin
                        n_vic_found = 1'b1;
                        n_vic_idx   = r_pidx;
                        n_vic_rank  = i_rd_rank;
                    end
                    if (i_rd_rank == '0) begin
                        n_zero_idx = r_pidx;
                    end
                end
                if (r_cnt == CNT_END) begin
                    n_state = S_FETCH;
                end
            end

            S_FETCH: begin
                if (r_item.action == ACT_GET) begin
                    n_slot = r_hit_found ? r_hit_idx : (r_vic_found ? r_vic_idx : r_zero_idx);
                end else begin
                    n_slot = item_addr;
                end
                o_rd_addr       = n_slot;
                o_mem_ctl.rd_en = 1'b1;
                n_state         = S_UPDATE;
            end

            S_UPDATE: begin
                if (i_out_free) begin
                    o_done                = 1'b1;
                    o_result.result_slot  = r_item.slot_index;
                    n_state               = S_IDLE;
                    case (r_item.action)
                        ACT_GET: begin
                            o_result.result_slot = res_slot_x[4:0];
                            if (r_hit_found) begin
                                o_result.hit = 1'b1;
                                if (i_rd_row.ref_count != COUNT_MAX) begin
                                    row_n.ref_count = cnt_sum;
                                end
                            end else begin
                                if (i_rd_row.in_use && i_rd_row.dirty && i_rd_row.data_valid) begin
                                    o_result.write_back       = 1'b1;
                                    o_result.old_block_number = i_rd_row.tag_block;
                                end
                                o_result.forced_eviction = !r_vic_found;
                                row_n.in_use     = 1'b1;
                                row_n.data_valid = 1'b0;
                                row_n.dirty      = 1'b0;
                                row_n.ref_count  = 8'd1;
                                row_n.tag_device = r_item.device_id;
                                row_n.tag_block  = r_item.block_number;
                            end
                            if (!row_n.data_valid) begin
                                if (out_of_range) begin
                                    o_result.status = ST_RANGE;
                                end else begin
                                    o_result.fill_needed = 1'b1;
                                    row_n.data_valid     = 1'b1;
                                end
                            end
                            o_wr_row        = row_n;
                            o_mem_ctl.wr_en = 1'b1;
                        end
                        ACT_WRITE: begin
                            if (!ok_slot || !i_rd_row.data_valid) begin
                                o_result.status = ST_INVALID;
                            end else begin
                                row_n.dirty     = 1'b1;
                                o_wr_row        = row_n;
                                o_mem_ctl.wr_en = 1'b1;
                                if (out_of_range) begin
                                    o_result.status = ST_RANGE;
                                end else begin
                                    o_result.write_through = 1'b1;
                                end
                            end
                        end
                        ACT_RELEASE: begin
                            if (!ok_slot || (i_rd_row.ref_count == 8'd0)) begin
                                o_result.status = ST_UNREF;
                            end else begin
                                row_n.ref_count = cnt_sum;
                                o_wr_row        = row_n;
                                o_mem_ctl.wr_en = 1'b1;
                                if (cnt_sum == 8'd0) begin
                                    n_old_rank = i_rd_rank;
                                    n_cnt      = '0;
                                    n_state    = S_SWEEP;
                                end
                            end
                        end
                        ACT_PIN: begin
                            if (ok_slot && (i_rd_row.ref_count != COUNT_MAX)) begin
                                row_n.ref_count = cnt_sum;
                                o_wr_row        = row_n;
                                o_mem_ctl.wr_en = 1'b1;
                            end
                        end
                        ACT_UNPIN: begin
                            if (ok_slot && (i_rd_row.ref_count != 8'd0)) begin
                                row_n.ref_count = cnt_sum;
                                o_wr_row        = row_n;
                                o_mem_ctl.wr_en = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SWEEP: begin
                if (r_cnt != CNT_END) begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_pidx          = r_cnt[SW-1:0];
                    n_cnt           = r_cnt + 1'b1;
                end
                if (r_cnt != '0) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_wr_addr       = r_pidx;
                    if (r_pidx == r_slot) begin
                        o_wr_rank = RANK_TOP;
                    end else if (i_rd_rank > r_old_rank) begin
                        o_wr_rank = i_rd_rank - 1'b1;
                    end
                end
                if (r_cnt == CNT_END) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_cnt       <= n_cnt;
        r_pidx      <= n_pidx;
        r_hit_found <= n_hit_found;
        r_hit_idx   <= n_hit_idx;
        r_vic_found <= n_vic_found;
        r_vic_idx   <= n_vic_idx;
        r_vic_rank  <= n_vic_rank;
        r_zero_idx  <= n_zero_idx;
        r_slot      <= n_slot;
        r_old_rank  <= n_old_rank;
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for block_cache_directory: mirrors the slot directory,
// predicts every result and drives requests and the disk size under random idling.
// Depends on blkcd_pkg and the block_cache_directory RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import blkcd_pkg::*;

    localparam int SLOTS        = 32;
    localparam int IDLE_PCT     = 22;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;

    class cache_dir_tracker;
        logic [15:0] tag_dev [SLOTS];
        logic [31:0] tag_blk [SLOTS];
        bit          in_use  [SLOTS];
        bit   [7:0]  refs    [SLOTS];
        bit          loaded  [SLOTS];
        bit          dirty   [SLOTS];
        bit   [4:0]  rank    [SLOTS];
        bit   [31:0] disk_blocks;
        t_out        due_results [$];
        int          errors, matched, hits, forced, write_backs, out_of_range;

        function new();
            disk_blocks = DISK_BLOCKS_RST;
            for (int i = 0; i < SLOTS; i++) begin
                tag_dev[i] = '0;
                tag_blk[i] = '0;
                in_use[i]  = 1'b0;
                refs[i]    = '0;
                loaded[i]  = 1'b0;
                dirty[i]   = 1'b0;
                rank[i]    = 5'(SLOTS - 1 - i);
            end
            errors       = 0;
            matched      = 0;
            hits         = 0;
            forced       = 0;
            write_backs  = 0;
            out_of_range = 0;
        endfunction

        function void take_request(t_in req);
            t_out       res;
            int         s;
            int         best;
            logic [4:0] idx;
            bit   [4:0] old_rank;
            res = '0;
            idx = req.slot_index;
            res.result_slot = idx;
            case (req.action)
                ACT_GET: begin
                    s = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (s < 0 && in_use[i] && tag_dev[i] == req.device_id &&
                            tag_blk[i] == req.block_number)
                            s = i;
                    if (s >= 0) begin
                        res.hit = 1'b1;
                        if (refs[s] < COUNT_MAX)
                            refs[s]++;
                    end else begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (refs[i] == 0 && (best < 0 || rank[i] < rank[best]))
                                best = i;
                        if (best < 0) begin
                            res.forced_eviction = 1'b1;
                            best = 0;
                            for (int i = 0; i < SLOTS; i++)
                                if (rank[i] == 0)
                                    best = i;
                        end
                        s = best;
                        if (in_use[s] && dirty[s] && loaded[s]) begin
                            res.write_back       = 1'b1;
                            res.old_block_number = tag_blk[s];
                        end
                        tag_dev[s] = req.device_id;
                        tag_blk[s] = req.block_number;
                        in_use[s]  = 1'b1;
                        loaded[s]  = 1'b0;
                        dirty[s]   = 1'b0;
                        refs[s]    = 8'd1;
                    end
                    if (!loaded[s]) begin
                        if (req.block_number >= disk_blocks) begin
                            res.status = ST_RANGE;
                        end else begin
                            res.fill_needed = 1'b1;
                            loaded[s] = 1'b1;
                        end
                    end
                    res.result_slot = 5'(s);
                end
                ACT_WRITE: begin
                    if (!loaded[idx]) begin
                        res.status = ST_INVALID;
                    end else begin
                        dirty[idx] = 1'b1;
                        if (tag_blk[idx] >= disk_blocks)
                            res.status = ST_RANGE;
                        else
                            res.write_through = 1'b1;
                    end
                end
                ACT_RELEASE: begin
                    if (refs[idx] == 0) begin
                        res.status = ST_UNREF;
                    end else begin
                        refs[idx]--;
                        if (refs[idx] == 0) begin
                            old_rank = rank[idx];
                            for (int i = 0; i < SLOTS; i++)
                                if (rank[i] > old_rank)
                                    rank[i]--;
                            rank[idx] = 5'(SLOTS - 1);
                        end
                    end
                end
                ACT_PIN: begin
                    if (refs[idx] < COUNT_MAX)
                        refs[idx]++;
                end
                ACT_UNPIN: begin
                    if (refs[idx] != 0)
                        refs[idx]--;
                end
                default: begin
                end
            endcase
            hits         += int'(res.hit);
            forced       += int'(res.forced_eviction);
            write_backs  += int'(res.write_back);
            out_of_range += int'(res.status == ST_RANGE);
            due_results.push_back(res);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("MISMATCH at result %0d: %s", matched, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task match_result(t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = due_results.pop_front();
            check_field("result_slot", 32'(got.result_slot), 32'(want.result_slot));
            check_field("hit", 32'(got.hit), 32'(want.hit));
            check_field("fill_needed", 32'(got.fill_needed), 32'(want.fill_needed));
            check_field("write_back", 32'(got.write_back), 32'(want.write_back));
            check_field("old_block_number", got.old_block_number, want.old_block_number);
            check_field("forced_eviction", 32'(got.forced_eviction),
                        32'(want.forced_eviction));
            check_field("write_through", 32'(got.write_through),
                        32'(want.write_through));
            check_field("status", 32'(got.status), 32'(want.status));
            matched++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    t_in         req_data;
    logic        rsp_valid;
    logic        rsp_stall;
    t_out        rsp_data;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    cache_dir_tracker dir = new();
    int sent        = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit held_once   = 1'b0;

    block_cache_directory #(
        .SLOT_COUNT (SLOTS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // one long result hold, else random stalls outside a no-stall window
    always @(negedge clk) begin
        if (!held_once && sent >= 300) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
        end else if (dir.matched >= 800 && dir.matched < 950) begin
            rsp_stall = 1'b0;
        end else begin
            rsp_stall = ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall)
            dir.match_result(rsp_data);
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("block_cache_directory test failed");
            $finish;
        end
    end

    task automatic send_item(t_in item);
        while (!(sent >= 600 && sent < 760) && $urandom_range(99) < IDLE_PCT) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req_data  = item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        dir.take_request(item);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_op(logic [2:0] act, logic [15:0] dev, logic [31:0] blk,
                           logic [4:0] slot);
        t_in it;
        it.action       = act;
        it.device_id    = dev;
        it.block_number = blk;
        it.slot_index   = slot;
        send_item(it);
    endtask

    task automatic drain();
        req_valid = 1'b0;
        while (dir.due_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_disk_blocks(logic [31:0] value);
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        dir.disk_blocks = value;
    endtask

    function automatic logic [4:0] pick_slot(bit want_loaded);
        int pool[$];
        for (int i = 0; i < SLOTS; i++)
            if (want_loaded ? dir.loaded[i] : (dir.refs[i] != 0 && dir.refs[i] < 8))
                pool.push_back(i);
        if (pool.size() == 0 || $urandom_range(9) == 0)
            return 5'($urandom_range(SLOTS - 1));
        return 5'(pool[$urandom_range(pool.size() - 1)]);
    endfunction

    function automatic logic [31:0] near_block();
        case ($urandom_range(3))
            0: return 32'($urandom_range(15));
            1: return dir.disk_blocks + 32'($urandom_range(7)) - 32'd4;
            2: return 32'($urandom_range(63));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        t_in it;
        int  r;
        it.action       = ACT_GET;
        it.device_id    = 16'($urandom);
        it.block_number = $urandom;
        it.slot_index   = 5'($urandom_range(SLOTS - 1));
        r = $urandom_range(99);
        if (r < 36) begin
            if ($urandom_range(7) != 0) begin
                it.device_id    = 16'($urandom_range(3));
                it.block_number = near_block();
            end
        end else if (r < 56) begin
            it.action     = ACT_RELEASE;
            it.slot_index = pick_slot(1'b0);
        end else if (r < 72) begin
            it.action = ACT_WRITE;
            if ($urandom_range(4) != 0)
                it.slot_index = pick_slot(1'b1);
        end else if (r < 82) begin
            it.action = ACT_PIN;
        end else if (r < 92) begin
            it.action = ACT_UNPIN;
            if ($urandom_range(1) != 0)
                it.slot_index = pick_slot(1'b0);
        end else if (r < 96) begin
            it.action = 3'($urandom_range(ACT_UNKNOWN_HI, ACT_UNKNOWN_LO));
        end else begin
            it.action = ($urandom_range(1) != 0) ? ACT_RELEASE : ACT_WRITE;
        end
        send_item(it);
    endtask

    // reference every slot so gets start forcing evictions, then let go again
    task automatic crowd_slots();
        repeat (SLOTS + 4 + $urandom_range(4)) begin
            send_op(ACT_GET, 16'($urandom_range(255, 4)), near_block(), 5'($urandom));
            if ($urandom_range(4) == 0)
                send_op(ACT_WRITE, 16'($urandom), $urandom, pick_slot(1'b1));
        end
        repeat (2 * SLOTS)
            send_op(ACT_RELEASE, 16'($urandom), $urandom, pick_slot(1'b0));
    endtask

    task automatic run_phase(int count, bit pause_mid);
        int stop;
        int mid;
        bit crowded;
        stop    = sent + count;
        mid     = sent + count / 2;
        crowded = 1'b0;
        while (sent < stop) begin
            if (!crowded && sent >= mid) begin
                crowded = 1'b1;
                if (pause_mid)
                    drain();
                crowd_slots();
            end else begin
                send_random();
            end
        end
    endtask

    initial begin
        int sat_slot;
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        rsp_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        send_op(ACT_GET, 16'h0000, 32'h0000_0000, 5'd0);
        send_op(ACT_GET, 16'h0000, 32'h0000_0000, 5'd31);
        send_op(ACT_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
        send_op(ACT_WRITE, 16'h0000, 32'h0000_0000, 5'd30);
        send_op(ACT_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0);
        send_op(ACT_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
        send_op(ACT_GET, 16'h0001, 32'd4095, 5'd0);
        send_op(ACT_GET, 16'h0001, 32'd4096, 5'd0);
        send_op(ACT_RELEASE, 16'h0000, 32'h0000_0000, 5'd0);
        send_op(ACT_RELEASE, 16'h0000, 32'h0000_0000, 5'd31);
        send_op(ACT_RELEASE, 16'h0000, 32'h0000_0000, 5'd31);
        send_op(ACT_GET, 16'h0001, 32'h0000_0000, 5'd0);
        send_op(ACT_GET, 16'h0000, 32'h0000_0000, 5'd0);
        send_op(ACT_PIN, 16'h0000, 32'h0000_0000, 5'd5);
        send_op(ACT_UNPIN, 16'h0000, 32'h0000_0000, 5'd5);
        send_op(ACT_UNPIN, 16'h0000, 32'h0000_0000, 5'd5);
        send_op(ACT_UNKNOWN_LO, 16'h0000, 32'h0000_0000, 5'd0);
        send_op(ACT_UNKNOWN_LO + 3'd1, 16'h1234, 32'h0000_0100, 5'd31);
        send_op(ACT_UNKNOWN_HI, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
        send_op(ACT_WRITE, 16'h0000, 32'h0000_0000, 5'd31);
        send_op(ACT_GET, 16'hAAAA, 32'h5555_5555, 5'd21);
        send_op(ACT_GET, 16'h5555, 32'hAAAA_AAAA, 5'd10);
        send_op(ACT_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 5'd30);
        run_phase(200, 1'b0);

        set_disk_blocks(32'd1);
        run_phase(150, 1'b0);

        set_disk_blocks(32'hFFFF_FFFF);
        send_op(ACT_GET, 16'h0C0D, 32'd7, 5'd0);
        sat_slot = 0;
        for (int i = 0; i < SLOTS; i++)
            if (dir.in_use[i] && dir.tag_dev[i] == 16'h0C0D && dir.tag_blk[i] == 32'd7)
                sat_slot = i;
        repeat (260)
            send_op(ACT_PIN, 16'($urandom), $urandom, 5'(sat_slot));
        send_op(ACT_GET, 16'h0C0D, 32'd7, 5'($urandom));
        repeat (2)
            send_op(ACT_UNPIN, 16'($urandom), $urandom, 5'(sat_slot));
        run_phase(60, 1'b0);

        set_disk_blocks(32'($urandom_range(5000, 16)));
        run_phase(200, 1'b1);

        set_disk_blocks(32'd64);
        run_phase(120, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d requests over five disk sizes; %0d results compared, %0d mismatches.",
                 sent, dir.matched, dir.errors);
        $display("Seen: %0d hits, %0d forced evictions, %0d write-backs, %0d out of range.",
                 dir.hits, dir.forced, dir.write_backs, dir.out_of_range);
        if (dir.errors == 0) begin
            $display("block_cache_directory test passed");
        end else begin
            $display("block_cache_directory test failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/blkcd_pkg.sv
hw/rtl/blkcd_slot_store.sv
hw/rtl/blkcd_ctrl.sv
hw/rtl/block_cache_directory.sv
tb/testbench.sv
